// ===== rtl/core/gba_pkg.sv =====
// shared types and codes of the group-by aggregation table
package gba_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    // configuration register indexes
    localparam logic REG_AGG_MODE  = 1'b0;
    localparam logic REG_CAP_LIMIT = 1'b1;

    // aggregate modes
    localparam logic [1:0] MODE_COUNT = 2'd0;
    localparam logic [1:0] MODE_SUM   = 2'd1;
    localparam logic [1:0] MODE_AVG   = 2'd2;

    // input actions
    localparam logic ACT_ACCUM = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic                    action;
        logic signed [KEY_W-1:0] group_key;
        logic signed [VAL_W-1:0] row_value;
        logic                    value_null;
    } t_in_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] out_key;
        logic signed [VAL_W-1:0] out_total;
        logic signed [VAL_W-1:0] out_rows;
        logic                    last;
    } t_out_item;

    typedef struct packed {
        logic       reg_index;
        logic [5:0] wr_data;
    } t_cfg_item;

    // contents of one table cell
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] total;
        logic [VAL_W-1:0] rows;
    } t_entry;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic             cmp_en;
        logic [KEY_W-1:0] key_in;
        logic             upd_en;
        logic             any_hit;
        logic             shift_en;
        logic [1:0]       mode;
        logic [VAL_W-1:0] row_value;
        logic             value_null;
    } t_cell_ctl;

endpackage

// ===== rtl/core/gba_chan.sv =====
// valid/ready channel carrying one payload item
interface gba_chan #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/gba_cell.sv =====
// one group slot: key compare, aggregate update, insert and shift to its neighbor
module gba_cell
    import gba_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_prev_valid,
    input  t_entry    i_next,
    output t_entry    o_entry,
    output logic      o_match
);

    t_entry r_entry, n_entry;
    logic   r_match, n_match;
    logic [VAL_W-1:0] w_addend;

    always_comb begin
        n_entry = r_entry;
        n_match = r_match;
        w_addend = (i_ctl.mode == MODE_COUNT) ? VAL_W'(1) : i_ctl.row_value;
        if (i_ctl.cmp_en) begin
            n_match = r_entry.valid && (r_entry.key == i_ctl.key_in);
        end
        if (i_ctl.shift_en) begin
            n_entry = i_next;
        end else if (i_ctl.upd_en) begin
            if (i_ctl.any_hit) begin
                // update of the matching group, null rows leave it alone
                if (r_match && !i_ctl.value_null) begin
                    case (i_ctl.mode)
                        MODE_COUNT, MODE_SUM: begin
                            n_entry.total = r_entry.total + w_addend;
                        end
                        MODE_AVG: begin
                            n_entry.total = r_entry.total + w_addend;
                            n_entry.rows  = r_entry.rows + VAL_W'(1);
                        end
                        default: ;
                    endcase
                end
            end else if (!r_entry.valid && i_prev_valid) begin
                // first free slot takes the new key
                n_entry.valid = 1'b1;
                n_entry.key   = i_ctl.key_in;
                n_entry.total = '0;
                n_entry.rows  = '0;
                if (!i_ctl.value_null) begin
                    case (i_ctl.mode)
                        MODE_COUNT: n_entry.total = VAL_W'(1);
                        MODE_SUM:   n_entry.total = i_ctl.row_value;
                        MODE_AVG: begin
                            n_entry.total = i_ctl.row_value;
                            n_entry.rows  = VAL_W'(1);
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry.key   <= n_entry.key;
        r_entry.total <= n_entry.total;
        r_entry.rows  <= n_entry.rows;
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
            r_match       <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
            r_match       <= n_match;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

// ===== rtl/core/group_by_aggregate_table.sv =====
// top level of the group-by aggregation table: cell chain, sequencer and output stage
//
//   channel  dir  modport  payload      accepted when
//   i_in     in   sink     t_in_item    i_in.valid  && i_in.ready
//   o_out    out  source   t_out_item   o_out.valid && o_out.ready
//   i_cfg    in   sink     t_cfg_item   i_cfg.valid && i_cfg.ready
//
// an accumulate item: keys are compared in every cell as the item is accepted, the hit
// or the insert is applied in the next cycle
// a flush item, and an accumulate that spills, drain all stored groups: the chain
// shifts toward cell 0 one group per cycle, output stalls hold it
// reset (synchronous, active low) empties the table, restores the registers and
// drops the output item; i_in.ready is low while an item is compared or the table drains
module group_by_aggregate_table
    import gba_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gba_chan.sink             i_in,
    gba_chan.source           o_out,
    gba_chan.sink             i_cfg
);

    localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CMP   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [OCC_W-1:0] r_occ, n_occ;
    logic [1:0]       r_mode;
    logic [5:0]       r_cap;
    t_in_item         r_item;
    t_out_item        r_out;
    logic             r_out_valid;

    t_cell_ctl          w_ctl;
    t_entry             w_entry [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_valid_vec;
    logic [TABLE_ENTRIES-1:0] w_match_vec;
    logic               w_in_acc;
    logic               w_any_hit;
    logic               w_take;
    logic [OCC_W-1:0]   w_occ_inc;
    logic               w_spill;

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_any_hit = |w_match_vec;
    // during a drain, the head of the chain moves to the output register when that register is free
    assign w_take    = (r_state == ST_DRAIN) && w_entry[0].valid
                       && (!r_out_valid || o_out.ready);
    assign w_occ_inc = r_occ + OCC_W'(1);
    assign w_spill   = (8'(w_occ_inc) > 8'(r_cap)) || (8'(w_occ_inc) >= 8'(TABLE_ENTRIES));

    // control broadcast to the cells
    always_comb begin
        w_ctl.cmp_en     = w_in_acc && (i_in.payload.action == ACT_ACCUM);
        w_ctl.key_in     = (r_state == ST_CMP) ? r_item.group_key : i_in.payload.group_key;
        w_ctl.upd_en     = (r_state == ST_CMP);
        w_ctl.any_hit    = w_any_hit;
        w_ctl.shift_en   = w_take;
        w_ctl.mode       = r_mode;
        w_ctl.row_value  = r_item.row_value;
        w_ctl.value_null = r_item.value_null;
    end

    // the cell chain; valid groups always sit in the lowest slots
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        logic   w_prev_valid;
        t_entry w_next;
        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_valid = w_entry[g-1].valid;
        end
        if (g == TABLE_ENTRIES - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_link
            assign w_next = w_entry[g+1];
        end
        gba_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_prev_valid (w_prev_valid),
            .i_next       (w_next),
            .o_entry      (w_entry[g]),
            .o_match      (w_match_vec[g])
        );
        assign w_valid_vec[g] = w_entry[g].valid;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_occ   = r_occ;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.payload.action == ACT_FLUSH) begin
                        n_state = ST_DRAIN;
                        n_occ   = '0;
                    end else begin
                        n_state = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                if (w_any_hit) begin
                    n_state = ST_IDLE;
                end else if (w_spill) begin
                    // the new group goes out with the rest
                    n_state = ST_DRAIN;
                    n_occ   = '0;
                end else begin
                    n_state = ST_IDLE;
                    n_occ   = w_occ_inc;
                end
            end
            ST_DRAIN: begin
                if (!w_entry[0].valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_COUNT;
            r_cap  <= 6'd63;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.payload.reg_index)
                REG_AGG_MODE:  r_mode <= i_cfg.payload.wr_data[1:0];
                REG_CAP_LIMIT: r_cap  <= i_cfg.payload.wr_data;
                default: ;
            endcase
        end
    end

    // item and output payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= i_in.payload;
        end
        if (w_take) begin
            r_out.out_key   <= w_entry[0].key;
            r_out.out_total <= w_entry[0].total;
            // row count is reported in average mode only
            r_out.out_rows  <= (r_mode == MODE_AVG) ? w_entry[0].rows : '0;
            r_out.last      <= !w_entry[1].valid;
        end
    end

    assign i_in.ready    = (r_state == ST_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

`ifndef SYNTHESIS
    // occupied slots form a run starting at slot 0
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid_vec & (w_valid_vec + 1'b1)) == '0)
        else $error("valid slots not contiguous");

    // outside a drain the counter matches the stored groups
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_DRAIN) |-> ($countones(w_valid_vec) == 32'(r_occ)))
        else $error("occupancy out of step with cells");

    // keys are unique, so at most one cell matches
    a_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match_vec))
        else $error("more than one matching cell");

    // a group moved out of the chain shows up at the output
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (r_out_valid && !i_in.ready))
        else $error("drained group not presented");
`endif

endmodule
